// ===== rtl/core/rspm_pkg.sv =====
// shared types, constants and helpers for the resampling panned sample mixer
`timescale 1ns / 1ps

package rspm_pkg;

  localparam int MEM_DEPTH_DEF = 65536;
  localparam logic [15:0] STEP_RESET = 16'd10402;

  // address reduction steps: a 16-bit address is below 16 times the smallest depth (4096)
  localparam int MOD_STEPS = 4;

  localparam int SCALE_SHIFT = 5;
  localparam logic signed [5:0] LEVEL_FULL = 6'sd16;
  localparam logic signed [17:0] SAT_MAX = 18'sd32767;
  localparam logic signed [17:0] SAT_MIN = -18'sd32768;

  typedef enum logic [2:0] {
    FUNC_LOAD   = 3'd0,
    FUNC_START  = 3'd1,
    FUNC_STOP   = 3'd2,
    FUNC_LEVELS = 3'd3,
    FUNC_TICK   = 3'd4
  } func_t;

  // what a tick carries from the state update to the mixing stage
  typedef struct packed {
    logic               sound_on;
    logic               positioned;
    logic [4:0]         left_atten;
    logic [4:0]         right_atten;
    logic signed [15:0] music;
    logic               playing;
  } tick_ctx_t;

  function automatic logic signed [15:0] saturate16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[15:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[15:0];
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/rspm_ram.sv =====
// generic synchronous ram, one write port and one registered read port
`timescale 1ns / 1ps

module rspm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/rspm_mix.sv =====
// scales the played byte per side and mixes it into the music sample
`timescale 1ns / 1ps

module rspm_mix import rspm_pkg::*; (
  input  tick_ctx_t          ctx,
  input  logic [7:0]         rd_byte,
  output logic signed [15:0] left_mix,
  output logic signed [15:0] right_mix
);

  logic signed [15:0] samp;
  logic signed [16:0] left_scaled;
  logic signed [16:0] right_scaled;
  logic signed [16:0] quarter;
  logic signed [15:0] left_sat;
  logic signed [15:0] right_sat;

  // product divided by 32, truncated toward zero
  function automatic logic signed [16:0] scale_side(input logic signed [15:0] s,
                                                    input logic [4:0] level);
    logic signed [5:0]  factor;
    logic signed [21:0] prod;
    logic signed [21:0] adj;
    factor = LEVEL_FULL - $signed({1'b0, level});
    prod = s * factor;
    adj = (prod < 0) ? prod + 22'sd31 : prod;
    return adj[SCALE_SHIFT +: 17];
  endfunction

  // (byte - 128) * 256 is the byte with its top bit flipped, moved up a byte
  assign samp = $signed({~rd_byte[7], rd_byte[6:0], 8'h00});
  assign left_scaled = scale_side(samp, ctx.left_atten);
  assign right_scaled = scale_side(samp, ctx.right_atten);
  assign quarter = 17'(samp >>> 2);

  always_comb begin
    if (ctx.positioned) begin
      left_sat = saturate16(18'(left_scaled) + 18'(ctx.music));
      right_sat = saturate16(18'(right_scaled) + 18'(ctx.music));
    end else begin
      left_sat = saturate16(18'(quarter) + 18'(ctx.music));
      right_sat = left_sat;
    end
    if (ctx.sound_on) begin
      left_mix = left_sat;
      right_mix = right_sat;
    end else begin
      left_mix = ctx.music;
      right_mix = ctx.music;
    end
  end

endmodule

// ===== rtl/core/resampling_panned_sample_mixer.sv =====
// top level: sample playback with phase stepping, panning and music mix
`timescale 1ns / 1ps
//
//  channel   direction  handshake             payload
//  in        sink       in_valid / in_ready   func, address, sample_byte, sound_length,
//                                             positioned, left_level, right_level,
//                                             music_sample
//  out       source     out_valid / out_ready left_sample, right_sample, playing
//  cfg       sink       cfg_wr_en             cfg_wr_data (phase step)
//
// one item per cycle while in_ready is high; a tick's frame passes through
// the sample memory read stage, then the output register
// position update ignores the read data, so back-to-back ticks need no interlock
// in_ready drops only while both the read stage and the output register are full
// reset clears the playback state; the sample memory is not cleared and holds
// nothing defined until loaded

module resampling_panned_sample_mixer import rspm_pkg::*; #(
  parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         func,
  input  logic [15:0]        address,
  input  logic [7:0]         sample_byte,
  input  logic [16:0]        sound_length,
  input  logic               positioned,
  input  logic [4:0]         left_level,
  input  logic [4:0]         right_level,
  input  logic signed [15:0] music_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] left_sample,
  output logic signed [15:0] right_sample,
  output logic               playing,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);

  localparam int AW = $clog2(MEM_DEPTH);
  localparam int MW = AW + MOD_STEPS;

  logic [15:0]        phase_step;
  logic [16:0]        pos_int;
  logic [15:0]        pos_frac;
  logic [16:0]        rem_len;
  logic               active;
  logic               pos_mark;
  logic [4:0]         left_atten;
  logic [4:0]         right_atten;
  logic [AW-1:0]      rd_addr;
  logic               s1_valid;
  tick_ctx_t          s1_ctx;
  tick_ctx_t          tick_ctx;

  logic               accept;
  logic               tick_acc;
  logic               advance;
  logic [16:0]        frac_sum;
  logic [16:0]        int_next;
  logic               ended;
  logic [AW-1:0]      addr_inc;
  logic [AW-1:0]      load_addr;
  logic [AW-1:0]      start_addr;
  logic [7:0]         rd_byte;
  logic signed [15:0] left_mix;
  logic signed [15:0] right_mix;

  // address modulo depth by MOD_STEPS compare and subtract steps
  function automatic logic [AW-1:0] wrap_addr(input logic [15:0] a);
    logic [MW-1:0] r;
    r = MW'(a);
    for (int i = MOD_STEPS - 1; i >= 0; i--) begin
      if (r >= (MW'(MEM_DEPTH) << i)) begin
        r = r - (MW'(MEM_DEPTH) << i);
      end
    end
    return r[AW-1:0];
  endfunction

  assign advance = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign accept = in_valid && in_ready;
  assign tick_acc = accept && (func == FUNC_TICK);

  // the step is below one, so the integer part moves by the fraction carry alone
  assign frac_sum = {1'b0, pos_frac} + {1'b0, phase_step};
  assign int_next = pos_int + 17'(frac_sum[16]);
  assign ended = (int_next >= rem_len);
  assign addr_inc = (rd_addr == AW'(MEM_DEPTH - 1)) ? '0 : rd_addr + 1'b1;
  assign load_addr = wrap_addr(address);
  assign start_addr = load_addr;

  always_comb begin
    tick_ctx.sound_on = active;
    tick_ctx.positioned = pos_mark;
    tick_ctx.left_atten = left_atten;
    tick_ctx.right_atten = right_atten;
    tick_ctx.music = music_sample;
    tick_ctx.playing = active && !ended;
  end

  rspm_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept && (func == FUNC_LOAD)),
    .waddr (load_addr),
    .wdata (sample_byte),
    .re    (tick_acc && active),
    .raddr (rd_addr),
    .rdata (rd_byte)
  );

  rspm_mix u_mix (
    .ctx       (s1_ctx),
    .rd_byte   (rd_byte),
    .left_mix  (left_mix),
    .right_mix (right_mix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= STEP_RESET;
      pos_int <= '0;
      pos_frac <= '0;
      rem_len <= '0;
      active <= 1'b0;
      pos_mark <= 1'b0;
      left_atten <= '0;
      right_atten <= '0;
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        phase_step <= cfg_wr_data;
      end
      if (accept) begin
        unique case (func)
          FUNC_START: begin
            rd_addr <= start_addr;
            rem_len <= sound_length;
            pos_int <= '0;
            pos_frac <= '0;
            active <= 1'b1;
            pos_mark <= positioned;
            if (positioned) begin
              left_atten <= left_level;
              right_atten <= right_level;
            end
          end
          FUNC_STOP: begin
            active <= 1'b0;
          end
          FUNC_LEVELS: begin
            if (pos_mark) begin
              left_atten <= left_level;
              right_atten <= right_level;
            end
          end
          FUNC_TICK: begin
            if (active) begin
              pos_frac <= frac_sum[15:0];
              pos_int <= int_next;
              if (frac_sum[16]) begin
                rd_addr <= addr_inc;
              end
              if (ended) begin
                active <= 1'b0;
                pos_mark <= 1'b0;
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (in_ready) begin
        s1_valid <= tick_acc;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1_ctx <= tick_ctx;
    end
    if (advance && s1_valid) begin
      left_sample <= left_mix;
      right_sample <= right_mix;
      playing <= s1_ctx.playing;
    end
  end

endmodule

// ===== rtl/core/rspm_checker.sv =====
// port-level checks for the mixer, bound to the top level
`timescale 1ns / 1ps

module rspm_checker import rspm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [2:0]         func,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] left_sample,
  input logic signed [15:0] right_sample,
  input logic               playing
);

  // a frame is only ever started by a tick beat, by way of the read stage
  a_frame_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && func == FUNC_TICK, 2))
    else $error("frame appeared without a tick beat two cycles earlier");

  // input back-pressure only comes from a stalled output
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while output side is free");

  a_reset_empties_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output beat present right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(left_sample)
      && $stable(right_sample) && $stable(playing)))
    else $error("stalled output beat changed or vanished");

endmodule

bind resampling_panned_sample_mixer rspm_checker u_rspm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .func         (func),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .left_sample  (left_sample),
  .right_sample (right_sample),
  .playing      (playing)
);
